FILE: hw/rtl/hsd_pkg.sv
// Shared types and constants for the Huffman stream decoder.
// No dependencies.

package hsd_pkg;

   localparam int SYMBOL_W = 8;
   localparam int PTR_W    = 9;
   localparam int ENTRY_W  = 10;
   localparam int LEAF_BIT = 9;

   localparam logic [1:0] HEADER_LAST = 2'd3;
   localparam logic [3:0] LEAF_LAST   = 4'd8;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TREE,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_WAIT,
      ST_FLUSH
   } state_type;

   typedef enum logic {
      WK_TREE,
      WK_DATA
   } wait_kind_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] sym;
      logic                fin;
      logic                err;
   } result_type;

endpackage

FILE: hw/rtl/hsd_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.

module hsd_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/huffman_stream_decoder_top.sv
// Huffman stream decoder top level: header, preorder tree build, data walk.
// Depends on hsd_pkg and hsd_ram.
//
// Usage:
//   req_* carries compressed bytes; req_tuser marks the first header byte of
//   a stream and restarts the parser. rsp_* carries decoded symbols; rsp_tlast
//   marks the last result caused by one input byte.
//   Header bytes are taken in the idle state and give no result. Other bytes
//   are worked bit by bit after the accept step: a tree bit in the bit state
//   alone, a leaf that closes a pending branch with a wait state added (stack
//   memory read), a data bit walking the node table with a wait state (one
//   table read), a single-leaf tree bit in the bit state alone; a flush state
//   then releases the last result. One byte is worked at a time.
//   The node table and branch stack are synchronous RAMs, not cleared at
//   reset; the decoder only reads entries of a completed tree.
//   Reset returns the parser to the header phase and drops buffered results.
//   A stalled receiver holds the output register; one more result waits in a
//   hold stage, after which the bit walk pauses until a transfer frees space.

module huffman_stream_decoder_top
   import hsd_pkg::*;
#(
   parameter int NODE_CAPACITY = 512,
   parameter int STACK_DEPTH   = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] start_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] decoded_symbol
   output logic       rsp_tlast,   // run_end
   output logic [1:0] rsp_tuser    // [0] final_symbol, [1] error_flag
);

   localparam int AW  = $clog2(NODE_CAPACITY);
   localparam int NW  = $clog2(NODE_CAPACITY + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [1:0]    hbs_ff, hbs_in;
   logic [31:0]   symleft_ff, symleft_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [NW-1:0] nodes_ff, nodes_in;
   logic [3:0]    lbt_ff, lbt_in;
   logic [7:0]    shift_ff, shift_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [7:0]    byte_ff, byte_in;
   logic [2:0]    bidx_ff, bidx_in;
   wait_kind_type wkind_ff, wkind_in;
   logic [ENTRY_W-1:0] root_ff, root_in;
   logic          hold_v_ff, hold_v_in;
   result_type    hold_ff, hold_in;
   logic          out_v_ff, out_v_in;
   result_type    out_ff, out_in;
   logic          out_last_ff, out_last_in;

   logic               tab_we, tab_re;
   logic [PTR_W-1:0]   tab_waddr, tab_raddr;
   logic [ENTRY_W-1:0] tab_wdata, tab_rdata;
   logic               stk_we, stk_re;
   logic [SAW-1:0]     stk_waddr, stk_raddr;
   logic [PTR_W-1:0]   stk_wdata, stk_rdata;

   logic accept, cur_bit, out_free, can_emit;
   logic t_fail, t_leaf_end, t_done, t_pop, d_root, d_walk, brk, w_leaf;
   logic emit_req, emit_err, stall, stop, to_wait, step;
   logic [7:0] emit_sym;
   logic [1:0] hb;
   logic [31:0] sl_base;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cur_bit    = byte_ff[bidx_ff];
   assign out_free   = !out_v_ff || rsp_tready;
   assign can_emit   = !hold_v_ff || out_free;

   // Per-bit decode
   assign t_fail = (state_ff == ST_BIT) && (phase_ff == PH_TREE) &&
      (((lbt_ff == 4'd0) && !cur_bit &&
        ((nodes_ff >= NW'(NODE_CAPACITY)) || (sp_ff >= SPW'(STACK_DEPTH)))) ||
       ((lbt_ff == LEAF_LAST) && (sp_ff != '0) &&
        (nodes_ff >= NW'(NODE_CAPACITY))));
   assign t_leaf_end = (state_ff == ST_BIT) && (phase_ff == PH_TREE) &&
                       (lbt_ff == LEAF_LAST);
   assign t_done = t_leaf_end && (sp_ff == '0);
   assign t_pop  = t_leaf_end && (sp_ff != '0) && (nodes_ff < NW'(NODE_CAPACITY));
   assign d_root = (state_ff == ST_BIT) && (phase_ff == PH_DATA) && root_ff[LEAF_BIT];
   assign d_walk = (state_ff == ST_BIT) && (phase_ff == PH_DATA) && !root_ff[LEAF_BIT];
   assign brk    = (state_ff == ST_BIT) &&
                   ((phase_ff == PH_DONE) || (phase_ff == PH_ERROR) ||
                    (phase_ff == PH_HEADER));
   assign w_leaf = (state_ff == ST_WAIT) && (wkind_ff == WK_DATA) &&
                   tab_rdata[LEAF_BIT];

   assign emit_req = t_fail || d_root || w_leaf;
   assign emit_err = t_fail;
   assign emit_sym = d_root ? root_ff[7:0] : tab_rdata[7:0];
   assign stall    = emit_req && !can_emit;
   assign stop     = t_fail || brk || (t_done && (symleft_ff == 32'd0)) ||
                     ((d_root || w_leaf) && (symleft_ff == 32'd1));
   assign to_wait  = t_pop || d_walk;
   assign step     = ((state_ff == ST_BIT) || (state_ff == ST_WAIT)) &&
                     !stall && !stop && !to_wait;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !(req_tuser || (phase_ff == PH_HEADER))) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT, ST_WAIT: begin
            if (!stall) begin
               if (stop) begin
                  state_in = ST_FLUSH;
               end else if (to_wait) begin
                  state_in = ST_WAIT;
               end else if (bidx_ff == 3'd0) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_BIT;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_v_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      phase_in    = phase_ff;
      hbs_in      = hbs_ff;
      symleft_in  = symleft_ff;
      sp_in       = sp_ff;
      nodes_in    = nodes_ff;
      lbt_in      = lbt_ff;
      shift_in    = shift_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      next_in     = next_ff;
      byte_in     = byte_ff;
      bidx_in     = bidx_ff;
      wkind_in    = wkind_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      tab_we      = 1'b0;
      tab_waddr   = pos_ff;
      tab_wdata   = {1'b1, 1'b0, shift_ff[6:0], cur_bit};
      tab_re      = 1'b0;
      tab_raddr   = next_ff;
      stk_we      = 1'b0;
      stk_waddr   = sp_ff[SAW-1:0];
      stk_wdata   = pos_ff;
      stk_re      = 1'b0;
      stk_raddr   = SAW'(sp_ff - SPW'(1));
      hb          = req_tuser ? 2'd0 : hbs_ff;
      sl_base     = req_tuser ? 32'd0 : symleft_ff;

      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  phase_in = PH_HEADER;
                  hbs_in   = 2'd0;
                  sp_in    = '0;
                  nodes_in = '0;
                  lbt_in   = 4'd0;
                  shift_in = 8'd0;
                  pos_in   = '0;
               end
               if (req_tuser || (phase_ff == PH_HEADER)) begin
                  symleft_in = {sl_base[23:0], req_tdata};
                  if (hb == HEADER_LAST) begin
                     hbs_in   = 2'd0;
                     phase_in = PH_TREE;
                     nodes_in = NW'(1);
                     sp_in    = '0;
                     pos_in   = '0;
                     lbt_in   = 4'd0;
                     shift_in = 8'd0;
                  end else begin
                     hbs_in = hb + 2'd1;
                  end
               end else begin
                  byte_in = req_tdata;
                  bidx_in = 3'd7;
               end
            end
         end
         ST_BIT: begin
            if (!stall) begin
               if (phase_ff == PH_TREE) begin
                  if (t_fail) begin
                     phase_in = PH_ERROR;
                  end else if (lbt_ff == 4'd0) begin
                     if (!cur_bit) begin
                        stk_we   = 1'b1;
                        sp_in    = sp_ff + SPW'(1);
                        pos_in   = PTR_W'(nodes_ff);
                        nodes_in = nodes_ff + NW'(1);
                     end else begin
                        lbt_in   = 4'd1;
                        shift_in = 8'd0;
                     end
                  end else begin
                     shift_in = {shift_ff[6:0], cur_bit};
                     lbt_in   = lbt_ff + 4'd1;
                     if (t_leaf_end) begin
                        lbt_in = 4'd0;
                        tab_we = 1'b1;
                        if (t_done) begin
                           pos_in   = '0;
                           cur_in   = root_ff[PTR_W-1:0];
                           phase_in = (symleft_ff == 32'd0) ? PH_DONE : PH_DATA;
                        end else begin
                           sp_in    = sp_ff - SPW'(1);
                           stk_re   = 1'b1;
                           wkind_in = WK_TREE;
                        end
                     end
                  end
               end else if (d_root) begin
                  symleft_in = symleft_ff - 32'd1;
                  if (symleft_ff == 32'd1) begin
                     phase_in = PH_DONE;
                  end
               end else if (d_walk) begin
                  next_in   = cur_bit ? (pos_ff + PTR_W'(1)) : cur_ff;
                  tab_re    = 1'b1;
                  tab_raddr = next_in;
                  wkind_in  = WK_DATA;
               end
            end
         end
         ST_WAIT: begin
            if (!stall) begin
               if (wkind_ff == WK_TREE) begin
                  tab_we    = 1'b1;
                  tab_waddr = stk_rdata;
                  tab_wdata = {1'b0, PTR_W'(nodes_ff)};
                  pos_in    = PTR_W'(nodes_ff);
                  nodes_in  = nodes_ff + NW'(1);
               end else if (w_leaf) begin
                  symleft_in = symleft_ff - 32'd1;
                  pos_in     = '0;
                  cur_in     = root_ff[PTR_W-1:0];
                  if (symleft_ff == 32'd1) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  pos_in = next_ff;
                  cur_in = tab_rdata[PTR_W-1:0];
               end
            end
         end
         ST_FLUSH: begin
            if (hold_v_ff && out_free) begin
               out_in      = hold_ff;
               out_last_in = 1'b1;
               out_v_in    = 1'b1;
               hold_v_in   = 1'b0;
            end
         end
         default: ;
      endcase

      if (step && (bidx_ff != 3'd0)) begin
         bidx_in = bidx_ff - 3'd1;
      end

      if (emit_req && !stall) begin
         if (hold_v_ff) begin
            out_in      = hold_ff;
            out_last_in = 1'b0;
            out_v_in    = 1'b1;
         end
         hold_v_in   = 1'b1;
         hold_in.sym = emit_err ? 8'd0 : emit_sym;
         hold_in.fin = !emit_err && (symleft_ff == 32'd1);
         hold_in.err = emit_err;
      end
   end

   assign root_in = (tab_we && (tab_waddr == '0)) ? tab_wdata : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_HEADER;
         hbs_ff     <= 2'd0;
         symleft_ff <= 32'd0;
         sp_ff      <= '0;
         nodes_ff   <= '0;
         lbt_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         pos_ff     <= '0;
         hold_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         hbs_ff     <= hbs_in;
         symleft_ff <= symleft_in;
         sp_ff      <= sp_in;
         nodes_ff   <= nodes_in;
         lbt_ff     <= lbt_in;
         shift_ff   <= shift_in;
         pos_ff     <= pos_in;
         hold_v_ff  <= hold_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      next_ff     <= next_in;
      byte_ff     <= byte_in;
      bidx_ff     <= bidx_in;
      wkind_ff    <= wkind_in;
      root_ff     <= root_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // Tree writes and data reads never target the same entry in one cycle.
   hsd_ram #(
      .DEPTH (NODE_CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_node_table (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr[AW-1:0]),
      .wr_data (tab_wdata),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr[AW-1:0]),
      .rd_data (tab_rdata)
   );

   hsd_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (PTR_W)
   ) u_branch_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_ff.sym;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_ff.fin;
   assign rsp_tuser[1] = out_ff.err;

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_v_ff)
      else $error("result left in hold stage while idle");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer past depth");

   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_ff <= NW'(NODE_CAPACITY))
      else $error("node count past capacity");

   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> ((rsp_tdata == 8'd0) && !rsp_tuser[0]))
      else $error("error result carries a symbol");

   a_emit_no_loss: assert property (@(posedge clock) disable iff (reset)
      (emit_req && !stall && hold_v_ff) |=> out_v_ff)
      else $error("held result dropped on emit");

endmodule
